@@ src/rfrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Route frame receive filter package
// Shared item types, verdict codes and register indexes.
// ----------------------------------------------------------------------------
package rfrf_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned IdW    = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned PosW   = 9;
  localparam int unsigned HopW   = 4;
  localparam int unsigned RouteW = 5;

  localparam logic [IdW-1:0]   ID_MASK    = 16'h8FFF;
  localparam logic [DataW-1:0] HOP_MASK   = 8'h0F;
  localparam logic [DataW-1:0] KEY_ASSIGN = 8'h01;
  localparam logic [DataW-1:0] KEY_READ   = 8'h03;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_GATEWAY_ID = 1'b0,
    CFG_MODULE_ID  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    VERDICT_WRONG_GATEWAY = 3'd0,
    VERDICT_OWN_SOURCE    = 3'd1,
    VERDICT_REPEAT        = 3'd2,
    VERDICT_FORWARD       = 3'd3,
    VERDICT_ASSIGN_ROUTE  = 3'd4,
    VERDICT_READ_DATA     = 3'd5,
    VERDICT_OTHER_LOCAL   = 3'd6,
    VERDICT_MALFORMED     = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [DataW-1:0] byte_in;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       verdict;
    logic [DataW-1:0] key;
    logic [DataW-1:0] request_id;
    logic [HopW-1:0]  hop_count;
    logic [DataW-1:0] hop_depth;
    logic [DataW-1:0] protocol_type;
    logic [IdW-1:0]   source_id;
    logic [IdW-1:0]   dest_id;
    logic [DataW-1:0] sum_computed;
    logic [DataW-1:0] sum_received;
  } out_item_t;

  typedef struct packed {
    logic [IdW-1:0] gateway_id;
    logic [IdW-1:0] module_id;
  } cfg_t;

  // Handshake between the input register, the parser and the result register.
  typedef struct packed {
    logic take;
    logic push;
  } flow_t;

endpackage

@@ src/route_frame_rx_filter.sv @@
// ----------------------------------------------------------------------------
// Route frame receive filter
// Parses mesh routing frames byte by byte and classifies each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one frame byte per item, frame_start set on the preamble
//   byte. Bytes with frame_start clear outside a frame are dropped silently,
//   and a new start byte inside a frame abandons that frame.
//   Output channel: one verdict item per complete frame, given when the
//   checksum byte (position length+2) has been taken, together with the
//   parsed header, the byte sum and the received checksum.
//   Configuration: gateway and own module address, written by index while
//   no frame is in flight.
//   Path: a byte waits in the input register, and at the checksum byte the
//   parser writes the verdict into the result register once that is free.
//   Throughput: one byte per cycle while the result register can take a verdict,
//   set by the single parser pass between the input and the result register.
//   Reset clears the frame state, the last id/source pair and both address
//   registers. When the receiver stalls, the verdict is held; following
//   bytes keep flowing until the next checksum byte, which waits in the
//   input register and then holds off further bytes.
// ----------------------------------------------------------------------------
module route_frame_rx_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rfrf_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rfrf_pkg::out_item_t        out_item_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rfrf_pkg::CfgW-1:0]  cfg_data_i
);
  import rfrf_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      held_valid;
  in_item_t  held_item;
  flow_t     flow;
  out_item_t result;
  logic      out_free;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GATEWAY_ID: cfg_d.gateway_id = cfg_data_i;
        CFG_MODULE_ID:  cfg_d.module_id  = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfrf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (flow.take),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  rfrf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (held_valid),
    .item_i     (held_item),
    .out_free_i (out_free),
    .flow_o     (flow),
    .result_o   (result)
  );

  rfrf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (flow.push),
    .item_i      (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ src/rfrf_in_reg.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte item until the parser consumes it.
// ----------------------------------------------------------------------------
module rfrf_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rfrf_pkg::in_item_t in_item_i,
  input  logic               take_i,
  output logic               valid_o,
  output rfrf_pkg::in_item_t item_o
);
  import rfrf_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/rfrf_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the byte position, picks header fields, sums the bytes and gives
// the verdict at the checksum byte.
// ----------------------------------------------------------------------------
module rfrf_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfrf_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  input  rfrf_pkg::in_item_t  item_i,
  input  logic                out_free_i,
  output rfrf_pkg::flow_t     flow_o,
  output rfrf_pkg::out_item_t result_o
);
  import rfrf_pkg::*;

  localparam logic [PosW-1:0] POS_LEN     = 9'd1;
  localparam logic [PosW-1:0] POS_RID     = 9'd2;
  localparam logic [PosW-1:0] POS_KEY     = 9'd3;
  localparam logic [PosW-1:0] POS_GW_HI   = 9'd4;
  localparam logic [PosW-1:0] POS_GW_LO   = 9'd5;
  localparam logic [PosW-1:0] POS_DIR     = 9'd6;
  localparam logic [PosW-1:0] POS_DEPTH   = 9'd7;
  localparam logic [PosW-1:0] POS_ROUTE   = 9'd8;
  localparam logic [PosW-1:0] OFF_PROTO   = 9'd0;
  localparam logic [PosW-1:0] OFF_SRC_HI  = 9'd1;
  localparam logic [PosW-1:0] OFF_SRC_LO  = 9'd2;
  localparam logic [PosW-1:0] OFF_DST_HI  = 9'd3;
  localparam logic [PosW-1:0] OFF_DST_LO  = 9'd4;
  localparam logic [PosW-1:0] MIN_HDR_LEN = 9'd11;

  logic              active_q, active_d;
  logic [PosW-1:0]   pos_q, pos_d, pos_b;
  logic [DataW-1:0]  len_q, len_d, len_b;
  logic [RouteW-1:0] route_q, route_d, route_b;
  logic [HopW-1:0]   hop_q, hop_d, hop_b;
  logic [IdW-1:0]    gw_q, gw_d, gw_b;
  logic [DataW-1:0]  rid_q, rid_d, rid_b;
  logic [DataW-1:0]  key_q, key_d, key_b;
  logic [DataW-1:0]  depth_q, depth_d, depth_b;
  logic [DataW-1:0]  proto_q, proto_d, proto_b;
  logic [IdW-1:0]    src_q, src_d, src_b;
  logic [IdW-1:0]    dst_q, dst_d, dst_b;
  logic [DataW-1:0]  sum_q, sum_d, sum_b;
  logic [DataW-1:0]  last_rid_q, last_rid_d;
  logic [IdW-1:0]    last_src_q, last_src_d;

  logic              fs, active_b, is_last, take;
  logic [DataW-1:0]  b;
  logic [HopW-1:0]   hop_new;
  logic [PosW-1:0]   route_base, rel;
  logic              malformed;
  verdict_e          verdict;

  assign fs = item_i.frame_start;
  assign b  = item_i.byte_in;

  // A start byte begins from a cleared frame.
  always_comb begin
    active_b = fs || active_q;
    pos_b    = fs ? '0 : pos_q;
    len_b    = fs ? '0 : len_q;
    route_b  = fs ? '0 : route_q;
    hop_b    = fs ? '0 : hop_q;
    gw_b     = fs ? '0 : gw_q;
    rid_b    = fs ? '0 : rid_q;
    key_b    = fs ? '0 : key_q;
    depth_b  = fs ? '0 : depth_q;
    proto_b  = fs ? '0 : proto_q;
    src_b    = fs ? '0 : src_q;
    dst_b    = fs ? '0 : dst_q;
    sum_b    = fs ? '0 : sum_q;
  end

  assign is_last = active_b && (pos_b == ({1'b0, len_b} + 9'd2));
  // An item that gives no result never waits for the result register.
  assign take    = valid_i && (!is_last || out_free_i);
  assign flow_o  = '{take: take, push: take && is_last};

  assign hop_new    = b[HopW-1:0] & HOP_MASK[HopW-1:0];
  assign route_base = POS_ROUTE + {4'b0, route_b};
  assign rel        = pos_b - route_base;
  assign malformed  = (hop_b == '0) ||
                      ({1'b0, len_b} < ({4'b0, route_b} + MIN_HDR_LEN));

  always_comb begin
    priority if (malformed) begin
      verdict = VERDICT_MALFORMED;
    end else if (gw_b != cfg_i.gateway_id) begin
      verdict = VERDICT_WRONG_GATEWAY;
    end else if (src_b == cfg_i.module_id) begin
      verdict = VERDICT_OWN_SOURCE;
    end else if (rid_b == last_rid_q && src_b == last_src_q) begin
      verdict = VERDICT_REPEAT;
    end else if ((cfg_i.module_id & ID_MASK) == (dst_b & ID_MASK)) begin
      if (key_b == KEY_ASSIGN) begin
        verdict = VERDICT_ASSIGN_ROUTE;
      end else if (key_b == KEY_READ) begin
        verdict = VERDICT_READ_DATA;
      end else begin
        verdict = VERDICT_OTHER_LOCAL;
      end
    end else begin
      verdict = VERDICT_FORWARD;
    end
  end

  always_comb begin
    result_o = '{
      verdict:       verdict,
      key:           key_b,
      request_id:    rid_b,
      hop_count:     hop_b,
      hop_depth:     depth_b,
      protocol_type: proto_b,
      source_id:     src_b,
      dest_id:       dst_b,
      sum_computed:  sum_b,
      sum_received:  b
    };
  end

  always_comb begin
    active_d   = active_q;
    pos_d      = pos_q;
    len_d      = len_q;
    route_d    = route_q;
    hop_d      = hop_q;
    gw_d       = gw_q;
    rid_d      = rid_q;
    key_d      = key_q;
    depth_d    = depth_q;
    proto_d    = proto_q;
    src_d      = src_q;
    dst_d      = dst_q;
    sum_d      = sum_q;
    last_rid_d = last_rid_q;
    last_src_d = last_src_q;
    if (take && active_b) begin
      pos_d   = pos_b;
      len_d   = len_b;
      route_d = route_b;
      hop_d   = hop_b;
      gw_d    = gw_b;
      rid_d   = rid_b;
      key_d   = key_b;
      depth_d = depth_b;
      proto_d = proto_b;
      src_d   = src_b;
      dst_d   = dst_b;
      sum_d   = sum_b;
      if (is_last) begin
        active_d = 1'b0;
        // Frames that get past the drop checks become the new last pair.
        if (verdict != VERDICT_MALFORMED && verdict != VERDICT_WRONG_GATEWAY &&
            verdict != VERDICT_OWN_SOURCE && verdict != VERDICT_REPEAT) begin
          last_rid_d = rid_b;
          last_src_d = src_b;
        end
      end else begin
        active_d = 1'b1;
        sum_d    = sum_b + b;
        pos_d    = pos_b + 9'd1;
        priority if (pos_b == POS_LEN) begin
          len_d = b;
        end else if (pos_b == POS_RID) begin
          rid_d = b;
        end else if (pos_b == POS_KEY) begin
          key_d = b;
        end else if (pos_b == POS_GW_HI) begin
          gw_d = {b, gw_b[DataW-1:0]};
        end else if (pos_b == POS_GW_LO) begin
          gw_d = {gw_b[IdW-1:DataW], b};
        end else if (pos_b == POS_DIR) begin
          hop_d   = hop_new;
          route_d = (hop_new != '0) ? {hop_new - 4'd1, 1'b0} : '0;
        end else if (pos_b == POS_DEPTH) begin
          depth_d = b;
        end else if (pos_b >= route_base) begin
          priority if (rel == OFF_PROTO) begin
            proto_d = b;
          end else if (rel == OFF_SRC_HI) begin
            src_d = {b, src_b[DataW-1:0]};
          end else if (rel == OFF_SRC_LO) begin
            src_d = {src_b[IdW-1:DataW], b};
          end else if (rel == OFF_DST_HI) begin
            dst_d = {b, dst_b[DataW-1:0]};
          end else if (rel == OFF_DST_LO) begin
            dst_d = {dst_b[IdW-1:DataW], b};
          end else begin
            sum_d = sum_b + b;
          end
        end else begin
          sum_d = sum_b + b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pos_q      <= '0;
      len_q      <= '0;
      route_q    <= '0;
      hop_q      <= '0;
      gw_q       <= '0;
      rid_q      <= '0;
      key_q      <= '0;
      depth_q    <= '0;
      proto_q    <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      sum_q      <= '0;
      last_rid_q <= '0;
      last_src_q <= '0;
    end else begin
      active_q   <= active_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      route_q    <= route_d;
      hop_q      <= hop_d;
      gw_q       <= gw_d;
      rid_q      <= rid_d;
      key_q      <= key_d;
      depth_q    <= depth_d;
      proto_q    <= proto_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      sum_q      <= sum_d;
      last_rid_q <= last_rid_d;
      last_src_q <= last_src_d;
    end
  end

endmodule

@@ src/rfrf_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one verdict item until the receiver takes it.
// ----------------------------------------------------------------------------
module rfrf_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rfrf_pkg::out_item_t item_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rfrf_pkg::out_item_t out_item_o
);
  import rfrf_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

@@ src/rfrf_checker.sv @@
// ----------------------------------------------------------------------------
// Route frame receive filter checker
// Port level properties, bound to the top level.
// ----------------------------------------------------------------------------
module rfrf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rfrf_pkg::out_item_t out_item_o
);
  import rfrf_pkg::*;

  // A held result stays put while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Input back pressure only comes from a pending result.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // Local verdicts agree with the key byte.
  a_local_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_item_o.verdict != VERDICT_ASSIGN_ROUTE || out_item_o.key == KEY_ASSIGN) &&
      (out_item_o.verdict != VERDICT_READ_DATA || out_item_o.key == KEY_READ) &&
      (out_item_o.verdict != VERDICT_OTHER_LOCAL ||
       (out_item_o.key != KEY_ASSIGN && out_item_o.key != KEY_READ)))
    else $error("local verdict does not match key");

  // Any frame that is not malformed had a nonzero hop count.
  a_hops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.verdict != VERDICT_MALFORMED |->
      out_item_o.hop_count != '0)
    else $error("well formed frame with zero hops");

endmodule

bind route_frame_rx_filter rfrf_checker u_rfrf_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route frame receive filter testbench
// Sends mesh routing frames one byte per item and checks every verdict item
// against a predictor of the frame parser, under several gateway and module
// address settings, with random gaps on the input and random stalls on the
// output.
// ----------------------------------------------------------------------------
module testbench;
  import rfrf_pkg::*;

  localparam int HOLD_CYCLES = 200;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_pace_e;

  // One frame to be sent; the length byte follows hops, payload and len_adj.
  typedef struct {
    logic [7:0]  pre;
    logic [7:0]  rid;
    logic [7:0]  key;
    logic [7:0]  dir;
    logic [7:0]  depth;
    logic [7:0]  proto;
    logic [15:0] gw;
    logic [15:0] src;
    logic [15:0] dst;
    int          payload;
    int          len_adj;
    bit          bad_sum;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_idx = CFG_GATEWAY_ID;
  logic [15:0] cfg_data = '0;

  // Predictor state: current frame, last accepted pair and register copies.
  logic [8:0]  rx_pos = '0;
  logic        rx_active = 1'b0;
  logic [7:0]  rx_len = '0;
  logic [4:0]  rx_route = '0;
  logic [3:0]  rx_hops = '0;
  logic [15:0] rx_gw = '0;
  logic [7:0]  rx_sum = '0;
  logic [7:0]  rx_rid = '0;
  logic [7:0]  rx_key = '0;
  logic [7:0]  rx_depth = '0;
  logic [7:0]  rx_proto = '0;
  logic [15:0] rx_src = '0;
  logic [15:0] rx_dst = '0;
  logic [7:0]  seen_rid = '0;
  logic [15:0] seen_src = '0;
  logic [15:0] my_gateway = '0;
  logic [15:0] my_module = '0;

  out_item_t   expected_verdicts[$];
  int          bytes_parsed = 0;
  int          verdicts_checked = 0;
  int          mismatches = 0;
  int          verdict_hits[8];
  int          burst_left = 0;
  bit          hold_request = 1'b0;

  route_frame_rx_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Advances the parser by one byte; returns 1 when the byte closes a frame.
  function automatic bit filter_byte(input in_item_t it, output out_item_t res);
    logic [7:0]  b;
    int unsigned p;
    int unsigned off;
    verdict_e    v;
    b = it.byte_in;
    res = '0;
    if (it.frame_start) begin
      rx_pos = '0; rx_len = '0; rx_route = '0; rx_hops = '0; rx_gw = '0; rx_sum = '0;
      rx_rid = '0; rx_key = '0; rx_depth = '0; rx_proto = '0; rx_src = '0; rx_dst = '0;
      rx_active = 1'b1;
    end else if (!rx_active) begin
      return 1'b0;
    end
    bytes_parsed++;
    p = rx_pos;
    if (p != rx_len + 32'd2) begin
      rx_sum = rx_sum + b;
      if (p == 1) rx_len = b;
      else if (p == 2) rx_rid = b;
      else if (p == 3) rx_key = b;
      else if (p == 4) rx_gw[15:8] = b;
      else if (p == 5) rx_gw[7:0] = b;
      else if (p == 6) begin
        rx_hops = b[3:0];
        rx_route = (rx_hops != 0) ? 5'(2 * (rx_hops - 1)) : 5'd0;
      end else if (p == 7) rx_depth = b;
      else if (p >= 8 + rx_route) begin
        // The network header follows the variable-length route list.
        off = p - 8 - rx_route;
        case (off)
          0: rx_proto = b;
          1: rx_src[15:8] = b;
          2: rx_src[7:0] = b;
          3: rx_dst[15:8] = b;
          4: rx_dst[7:0] = b;
          default: ;
        endcase
      end
      rx_pos = rx_pos + 9'd1;
      return 1'b0;
    end
    rx_active = 1'b0;
    if (rx_hops == 0 || rx_len < rx_route + 32'd11) v = VERDICT_MALFORMED;
    else if (rx_gw != my_gateway) v = VERDICT_WRONG_GATEWAY;
    else if (rx_src == my_module) v = VERDICT_OWN_SOURCE;
    else if (rx_rid == seen_rid && rx_src == seen_src) v = VERDICT_REPEAT;
    else begin
      seen_rid = rx_rid;
      seen_src = rx_src;
      if ((my_module & ID_MASK) != (rx_dst & ID_MASK)) v = VERDICT_FORWARD;
      else if (rx_key == KEY_ASSIGN) v = VERDICT_ASSIGN_ROUTE;
      else if (rx_key == KEY_READ) v = VERDICT_READ_DATA;
      else v = VERDICT_OTHER_LOCAL;
    end
    res.verdict       = v;
    res.key           = rx_key;
    res.request_id    = rx_rid;
    res.hop_count     = rx_hops;
    res.hop_depth     = rx_depth;
    res.protocol_type = rx_proto;
    res.source_id     = rx_src;
    res.dest_id       = rx_dst;
    res.sum_computed  = rx_sum;
    res.sum_received  = b;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (expected_verdicts.size() == 0) begin
      $error("verdict item 0x%0h arrived with none expected", got);
      mismatches++;
      return;
    end
    want = expected_verdicts.pop_front();
    check_field("verdict", 16'(want.verdict), 16'(got.verdict));
    check_field("key", 16'(want.key), 16'(got.key));
    check_field("request_id", 16'(want.request_id), 16'(got.request_id));
    check_field("hop_count", 16'(want.hop_count), 16'(got.hop_count));
    check_field("hop_depth", 16'(want.hop_depth), 16'(got.hop_depth));
    check_field("protocol_type", 16'(want.protocol_type), 16'(got.protocol_type));
    check_field("source_id", want.source_id, got.source_id);
    check_field("dest_id", want.dest_id, got.dest_id);
    check_field("sum_computed", 16'(want.sum_computed), 16'(got.sum_computed));
    check_field("sum_received", 16'(want.sum_received), 16'(got.sum_received));
    verdict_hits[want.verdict]++;
    verdicts_checked++;
  endtask

  // Output first, so that an item taken on this edge never meets its own result.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) check_verdict(out_item);
      if (in_valid && in_ready) begin
        if (filter_byte(in_item, want)) expected_verdicts.push_back(want);
      end
    end
  end

  initial begin : receiver
    rx_pace_e pace;
    int       left;
    int       i;
    pace = RX_STEADY;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (i = 1; i < HOLD_CYCLES; i++) @(negedge clk);
      end else begin
        if (left == 0) begin
          pace = rx_pace_e'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        case (pace)
          RX_STEADY: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{byte_in: b, frame_start: st};
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Sends a frame, or only its first cut bytes when cut is not negative.
  task automatic send_frame(input frame_t f, input int cut);
    logic [7:0] fb[$];
    logic [7:0] sum;
    int         hops;
    int         rb;
    int         len;
    hops = f.dir[3:0];
    rb = (hops != 0) ? 2 * (hops - 1) : 0;
    len = rb + 11 + f.payload + f.len_adj;
    if (len < 0) len = 0;
    if (len > 255) len = 255;
    fb.push_back(f.pre); fb.push_back(8'(len)); fb.push_back(f.rid); fb.push_back(f.key);
    fb.push_back(f.gw[15:8]); fb.push_back(f.gw[7:0]); fb.push_back(f.dir);
    fb.push_back(f.depth);
    repeat (rb) fb.push_back(8'($urandom));
    fb.push_back(f.proto); fb.push_back(f.src[15:8]); fb.push_back(f.src[7:0]);
    fb.push_back(f.dst[15:8]); fb.push_back(f.dst[7:0]);
    while (fb.size() < len + 2) fb.push_back(8'($urandom));
    while (fb.size() > len + 2) void'(fb.pop_back());
    sum = '0;
    foreach (fb[i]) sum = sum + fb[i];
    fb.push_back(f.bad_sum ? 8'($urandom) : sum);
    if (cut >= 0) begin
      while (fb.size() > cut) void'(fb.pop_back());
    end
    foreach (fb[i]) send_byte(fb[i], i == 0);
  endtask

  // Mostly frames that pass the length checks, biased toward each verdict.
  function automatic frame_t rand_frame();
    frame_t f;
    int     hops;
    int     pick;
    f.pre = 8'($urandom); f.rid = 8'($urandom); f.depth = 8'($urandom);
    f.proto = 8'($urandom);
    f.gw = ($urandom_range(0, 99) < 85) ? my_gateway : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) hops = 0;
    else if (pick < 70) hops = $urandom_range(1, 3);
    else hops = $urandom_range(4, 15);
    f.dir = {4'($urandom), 4'(hops)};
    f.src = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) f.src = my_module;
    else if (pick < 20) begin
      f.src = seen_src;
      f.rid = seen_rid;
    end
    f.dst = ($urandom_range(0, 99) < 45) ? ((my_module & ID_MASK) | (16'($urandom) & ~ID_MASK))
                                          : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) f.key = KEY_ASSIGN;
    else if (pick < 60) f.key = KEY_READ;
    else f.key = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) f.payload = 255;
    else if (pick < 8) f.payload = $urandom_range(20, 60);
    else f.payload = $urandom_range(0, 4);
    f.len_adj = ($urandom_range(0, 99) < 8) ? -int'($urandom_range(1, 12)) : 0;
    f.bad_sum = ($urandom_range(0, 3) == 0);
    return f;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    // A byte that closes no frame may still sit in the input register.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] gw, input logic [15:0] mod);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_GATEWAY_ID;
    cfg_data <= gw;
    @(negedge clk);
    cfg_idx <= CFG_MODULE_ID;
    cfg_data <= mod;
    @(negedge clk);
    cfg_we <= 1'b0;
    my_gateway = gw;
    my_module = mod;
  endtask

  task automatic test_special_frames();
    frame_t f;
    write_config(16'hA5C3, 16'h1234);
    // Bytes outside any frame are dropped.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // A zero length frame ends before the direction byte is seen.
    send_byte(8'hFF, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    // A new start abandons the open frame, also at the checksum position.
    send_byte(8'h00, 1'b1); send_byte(8'h14, 1'b0); send_byte(8'h55, 1'b0);
    send_byte(8'h80, 1'b1); send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h7E, 1'b0);
    f = rand_frame();
    f.dir = 8'hF0;
    f.gw = my_gateway;
    f.payload = 0;
    f.len_adj = 0;
    send_frame(f, -1);
    f = '{pre: 8'hFF, rid: 8'hFF, key: 8'hFF, dir: 8'hF1, depth: 8'hFF, proto: 8'hFF,
          gw: 16'hFFFF, src: 16'hFFFF, dst: 16'hFFFF, payload: 0, len_adj: 0,
          bad_sum: 1'b0};
    send_frame(f, -1);
  endtask

  task automatic test_random_traffic(input logic [15:0] gw, input logic [15:0] mod,
                                     input int n);
    frame_t f;
    int     goal;
    int     pick;
    write_config(gw, mod);
    goal = bytes_parsed + n;
    while (bytes_parsed < goal) begin
      pick = $urandom_range(0, 99);
      f = rand_frame();
      if (pick < 85) send_frame(f, -1);
      else if (pick < 93) repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      else send_frame(f, $urandom_range(1, 12));
    end
  endtask

  // The receiver stops while frames keep coming, so the block must stall input.
  task automatic test_receiver_hold();
    wait_idle();
    hold_request = 1'b1;
    burst_left = 100000;
    repeat (4) send_frame(rand_frame(), -1);
    burst_left = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_special_frames();
    test_random_traffic(16'h0000, 16'h0000, 340);
    test_receiver_hold();
    test_random_traffic(16'hFFFF, 16'hFFFF, 340);
    test_random_traffic(16'($urandom), 16'($urandom), 340);
    test_random_traffic(16'hFFFF, 16'h0000, 340);
    test_random_traffic(16'($urandom), 16'($urandom), 340);
    wait_idle();
    $display("Checked %0d verdict items from %0d parsed bytes across six address settings.",
             verdicts_checked, bytes_parsed);
    $display("Verdicts: gateway %0d, own %0d, repeat %0d, forward %0d, assign %0d, read %0d, other %0d, malformed %0d",
             verdict_hits[VERDICT_WRONG_GATEWAY], verdict_hits[VERDICT_OWN_SOURCE],
             verdict_hits[VERDICT_REPEAT], verdict_hits[VERDICT_FORWARD],
             verdict_hits[VERDICT_ASSIGN_ROUTE], verdict_hits[VERDICT_READ_DATA],
             verdict_hits[VERDICT_OTHER_LOCAL], verdict_hits[VERDICT_MALFORMED]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Run timed out with %0d verdict items outstanding.", expected_verdicts.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
